### rtl/mps_pkg.sv
// Package: types, register codes and constants for the motion primitive successor.
package mps_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int POS_FRAC_BITS_DEF = 16;

  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_SCALE     = 3'd0,
    CFG_STRAIGHT_STEP = 3'd1,
    CFG_TURN_STEP_X   = 3'd2,
    CFG_TURN_STEP_Y   = 3'd3,
    CFG_TURN_ANGLE    = 3'd4,
    CFG_GAIN_TURNING  = 3'd5,
    CFG_GAIN_DIR_CHG  = 3'd6,
    CFG_GAIN_REVERSE  = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] RST_POS_SCALE     = 16'd256;
  localparam logic [17:0] RST_STRAIGHT_STEP = 18'd46324;
  localparam logic [17:0] RST_TURN_STEP_X   = 18'd46217;
  localparam logic [17:0] RST_TURN_STEP_Y   = 18'd2726;
  localparam logic [15:0] RST_TURN_ANGLE    = 16'd1229;
  localparam logic [15:0] RST_GAIN_TURNING  = 16'd269;
  localparam logic [15:0] RST_GAIN_DIR_CHG  = 16'd512;
  localparam logic [15:0] RST_GAIN_REVERSE  = 16'd512;

  // sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [12:0] SIN_C = 13'd4640;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // motion codes
  localparam logic [2:0] MOT_STRAIGHT = 3'd0;
  localparam logic [2:0] MOT_TURN_A   = 3'd1;
  localparam logic [2:0] MOT_TURN_B   = 3'd2;
  localparam logic [2:0] MOT_REV_BASE = 3'd3;

  typedef struct packed {
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic [15:0]        parent_heading;
    logic [31:0]        parent_cost;
    logic [2:0]         parent_motion;
    logic [2:0]         motion_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] child_x;
    logic signed [31:0] child_y;
    logic [15:0]        child_heading;
    logic [31:0]        child_cost;
    logic               cost_saturated;
  } resp_t;

endpackage

### rtl/motion_primitive_successor.sv
// Top level: eight-stage pipelined hybrid A* node expansion.
// Throughput: one request per cycle; each stage holds one request and moves
//   on when the stage after it is empty or moving (per-stage ready chain).
// Reset: synchronous rst empties the pipeline and loads register defaults.
// The multiply chains of the sine polynomial and the cost gains set the depth.
module motion_primitive_successor #(
  parameter int ANGLE_BITS    = mps_pkg::ANGLE_BITS_DEF,
  parameter int POS_FRAC_BITS = mps_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  mps_pkg::req_t                    req,
  output logic                             resp_valid,
  input  logic                             resp_ready,
  output mps_pkg::resp_t                   resp,
  input  logic                             cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mps_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int QUAD_BITS = ANGLE_BITS - 2;
  localparam int POS_SHIFT = 40 - POS_FRAC_BITS;
  localparam int NST       = 8;
  localparam logic signed [54:0] HALF = 55'sd1 <<< (POS_SHIFT - 1);

  // configuration registers
  logic [15:0] pos_scale, turn_angle, gain_turning, gain_dir_chg, gain_reverse;
  logic [17:0] straight_step, turn_step_x, turn_step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_scale     <= mps_pkg::RST_POS_SCALE;
      straight_step <= mps_pkg::RST_STRAIGHT_STEP;
      turn_step_x   <= mps_pkg::RST_TURN_STEP_X;
      turn_step_y   <= mps_pkg::RST_TURN_STEP_Y;
      turn_angle    <= mps_pkg::RST_TURN_ANGLE;
      gain_turning  <= mps_pkg::RST_GAIN_TURNING;
      gain_dir_chg  <= mps_pkg::RST_GAIN_DIR_CHG;
      gain_reverse  <= mps_pkg::RST_GAIN_REVERSE;
    end else if (cfg_we) begin
      unique case (mps_pkg::cfg_idx_t'(cfg_addr))
        mps_pkg::CFG_POS_SCALE:     pos_scale     <= cfg_wdata[15:0];
        mps_pkg::CFG_STRAIGHT_STEP: straight_step <= cfg_wdata;
        mps_pkg::CFG_TURN_STEP_X:   turn_step_x   <= cfg_wdata;
        mps_pkg::CFG_TURN_STEP_Y:   turn_step_y   <= cfg_wdata;
        mps_pkg::CFG_TURN_ANGLE:    turn_angle    <= cfg_wdata[15:0];
        mps_pkg::CFG_GAIN_TURNING:  gain_turning  <= cfg_wdata[15:0];
        mps_pkg::CFG_GAIN_DIR_CHG:  gain_dir_chg  <= cfg_wdata[15:0];
        mps_pkg::CFG_GAIN_REVERSE:  gain_reverse  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NST-1:0] vld, en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || resp_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req_ready  = en[0];
  assign resp_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= req_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- stage 1: decode, trig argument, z squared, first gain
  logic [ANGLE_BITS-1:0] th, dth, ch_c;
  logic [1:0]            quad, quad_c;
  logic [QUAD_BITS+15:0] zw;
  logic [16:0]           z, zs_c, zc_c;
  logic [33:0]           zzs, zzc;
  logic                  rev_c, prev_c, chg_c;
  logic [2:0]            j;
  logic [17:0]           dx_c;
  logic signed [18:0]    dy, dyr_c;
  logic [33:0]           g1;
  logic [25:0]           m1_c;

  always_comb begin
    th     = ANGLE_BITS'(req.parent_heading);
    quad   = th[ANGLE_BITS-1 -: 2];
    quad_c = quad + 2'd1;
    zw     = {th[QUAD_BITS-1:0], 16'b0} >> QUAD_BITS;
    z      = zw[16:0];
    zs_c   = quad[0] ? mps_pkg::ONE_Q16 - z : z;
    zc_c   = quad[0] ? z : mps_pkg::ONE_Q16 - z;
    zzs    = zs_c * zs_c;
    zzc    = zc_c * zc_c;

    rev_c  = req.motion_index >= mps_pkg::MOT_REV_BASE;
    prev_c = req.parent_motion >= mps_pkg::MOT_REV_BASE;
    chg_c  = req.parent_motion != req.motion_index;
    j      = rev_c ? req.motion_index - mps_pkg::MOT_REV_BASE : req.motion_index;

    case (j)
      mps_pkg::MOT_TURN_A: begin
        dx_c = turn_step_x;
        dy   = -$signed({1'b0, turn_step_y});
        dth  = ANGLE_BITS'(turn_angle);
      end
      mps_pkg::MOT_TURN_B: begin
        dx_c = turn_step_x;
        dy   = $signed({1'b0, turn_step_y});
        dth  = -ANGLE_BITS'(turn_angle);
      end
      default: begin
        dx_c = straight_step;
        dy   = '0;
        dth  = '0;
      end
    endcase
    dyr_c = rev_c ? -dy : dy;
    ch_c  = rev_c ? th - dth : th + dth;

    g1   = straight_step * gain_turning + 34'd128;
    m1_c = chg_c ? g1[33:8] : 26'(straight_step);
  end

  logic signed [31:0]    s1_px, s1_py;
  logic [31:0]           s1_pc;
  logic [ANGLE_BITS-1:0] s1_ch;
  logic                  s1_rev, s1_dchg, s1_sneg, s1_cneg;
  logic [16:0]           s1_zs, s1_zc, s1_z2s, s1_z2c;
  logic [17:0]           s1_dx;
  logic signed [18:0]    s1_dyr;
  logic [25:0]           s1_m;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_px   <= req.parent_x;
      s1_py   <= req.parent_y;
      s1_pc   <= req.parent_cost;
      s1_ch   <= ch_c;
      s1_rev  <= rev_c;
      s1_dchg <= chg_c && (rev_c != prev_c);
      s1_sneg <= quad[1];
      s1_cneg <= quad_c[1];
      s1_zs   <= zs_c;
      s1_zc   <= zc_c;
      s1_z2s  <= zzs[32:16];
      s1_z2c  <= zzc[32:16];
      s1_dx   <= dx_c;
      s1_dyr  <= dyr_c;
      s1_m    <= m1_c;
    end
  end

  // ---------------- stage 2: B - z2*C, direction change gain
  logic [29:0] p2s, p2c;
  logic [41:0] g2;

  always_comb begin
    p2s = s1_z2s * mps_pkg::SIN_C;
    p2c = s1_z2c * mps_pkg::SIN_C;
    g2  = s1_m * gain_dir_chg + 42'd128;
  end

  logic signed [31:0]    s2_px, s2_py;
  logic [31:0]           s2_pc;
  logic [ANGLE_BITS-1:0] s2_ch;
  logic                  s2_rev, s2_sneg, s2_cneg;
  logic [16:0]           s2_zs, s2_zc, s2_z2s, s2_z2c;
  logic [15:0]           s2_t1s, s2_t1c;
  logic [17:0]           s2_dx;
  logic signed [18:0]    s2_dyr;
  logic [33:0]           s2_m;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_pc   <= s1_pc;
      s2_ch   <= s1_ch;
      s2_rev  <= s1_rev;
      s2_sneg <= s1_sneg;
      s2_cneg <= s1_cneg;
      s2_zs   <= s1_zs;
      s2_zc   <= s1_zc;
      s2_z2s  <= s1_z2s;
      s2_z2c  <= s1_z2c;
      s2_t1s  <= mps_pkg::SIN_B - p2s[29:16];
      s2_t1c  <= mps_pkg::SIN_B - p2c[29:16];
      s2_dx   <= s1_dx;
      s2_dyr  <= s1_dyr;
      s2_m    <= s1_dchg ? g2[41:8] : 34'(s1_m);
    end
  end

  // ---------------- stage 3: A - z2*t1, reversing gain
  logic [32:0] p3s, p3c;
  logic [49:0] g3;

  always_comb begin
    p3s = s2_z2s * s2_t1s;
    p3c = s2_z2c * s2_t1c;
    g3  = s2_m * gain_reverse + 50'd128;
  end

  logic signed [31:0]    s3_px, s3_py;
  logic [31:0]           s3_pc;
  logic [ANGLE_BITS-1:0] s3_ch;
  logic                  s3_rev, s3_sneg, s3_cneg;
  logic [16:0]           s3_zs, s3_zc, s3_t2s, s3_t2c;
  logic [17:0]           s3_dx;
  logic signed [18:0]    s3_dyr;
  logic [41:0]           s3_m;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_px   <= s2_px;
      s3_py   <= s2_py;
      s3_pc   <= s2_pc;
      s3_ch   <= s2_ch;
      s3_rev  <= s2_rev;
      s3_sneg <= s2_sneg;
      s3_cneg <= s2_cneg;
      s3_zs   <= s2_zs;
      s3_zc   <= s2_zc;
      s3_t2s  <= mps_pkg::SIN_A - p3s[32:16];
      s3_t2c  <= mps_pkg::SIN_A - p3c[32:16];
      s3_dx   <= s2_dx;
      s3_dyr  <= s2_dyr;
      s3_m    <= s2_rev ? g3[49:8] : 42'(s2_m);
    end
  end

  // ---------------- stage 4: z*t2, clamp and sign, cost sum
  logic [33:0]        p4s, p4c;
  logic [16:0]        vs, vc;
  logic [42:0]        csum;

  always_comb begin
    p4s  = s3_zs * s3_t2s;
    p4c  = s3_zc * s3_t2c;
    vs   = (p4s[33:16] > 18'(mps_pkg::ONE_Q16)) ? mps_pkg::ONE_Q16 : p4s[32:16];
    vc   = (p4c[33:16] > 18'(mps_pkg::ONE_Q16)) ? mps_pkg::ONE_Q16 : p4c[32:16];
    csum = 43'(s3_pc) + 43'(s3_m);
  end

  logic signed [31:0]    s4_px, s4_py;
  logic [ANGLE_BITS-1:0] s4_ch;
  logic                  s4_rev, s4_sat;
  logic signed [17:0]    s4_sin, s4_cos;
  logic [17:0]           s4_dx;
  logic signed [18:0]    s4_dyr;
  logic [31:0]           s4_cost;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_ch   <= s3_ch;
      s4_rev  <= s3_rev;
      s4_sin  <= s3_sneg ? -$signed({1'b0, vs}) : $signed({1'b0, vs});
      s4_cos  <= s3_cneg ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
      s4_dx   <= s3_dx;
      s4_dyr  <= s3_dyr;
      s4_sat  <= |csum[42:32];
      s4_cost <= (|csum[42:32]) ? '1 : csum[31:0];
    end
  end

  // ---------------- stage 5: rotation products
  logic signed [36:0] s5_dxc, s5_dys, s5_dxs, s5_dyc;
  logic signed [31:0] s5_px, s5_py;
  logic [ANGLE_BITS-1:0] s5_ch;
  logic               s5_rev, s5_sat;
  logic [31:0]        s5_cost;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_dxc  <= $signed({1'b0, s4_dx}) * s4_cos;
      s5_dxs  <= $signed({1'b0, s4_dx}) * s4_sin;
      s5_dys  <= s4_dyr * s4_sin;
      s5_dyc  <= s4_dyr * s4_cos;
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_ch   <= s4_ch;
      s5_rev  <= s4_rev;
      s5_sat  <= s4_sat;
      s5_cost <= s4_cost;
    end
  end

  // ---------------- stage 6: rotated offset sums
  logic signed [37:0] s6_rx, s6_ry;
  logic signed [31:0] s6_px, s6_py;
  logic [ANGLE_BITS-1:0] s6_ch;
  logic               s6_rev, s6_sat;
  logic [31:0]        s6_cost;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_rx   <= 38'(s5_dxc) - 38'(s5_dys);
      s6_ry   <= 38'(s5_dxs) + 38'(s5_dyc);
      s6_px   <= s5_px;
      s6_py   <= s5_py;
      s6_ch   <= s5_ch;
      s6_rev  <= s5_rev;
      s6_sat  <= s5_sat;
      s6_cost <= s5_cost;
    end
  end

  // ---------------- stage 7: scale
  logic signed [54:0] s7_vx, s7_vy;
  logic signed [31:0] s7_px, s7_py;
  logic [ANGLE_BITS-1:0] s7_ch;
  logic               s7_rev, s7_sat;
  logic [31:0]        s7_cost;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_vx   <= s6_rx * $signed({1'b0, pos_scale});
      s7_vy   <= s6_ry * $signed({1'b0, pos_scale});
      s7_px   <= s6_px;
      s7_py   <= s6_py;
      s7_ch   <= s6_ch;
      s7_rev  <= s6_rev;
      s7_sat  <= s6_sat;
      s7_cost <= s6_cost;
    end
  end

  // ---------------- stage 8: round half up, apply to position
  logic signed [54:0] rxw, ryw;
  logic [31:0]        offx, offy;

  always_comb begin
    rxw  = (s7_vx + HALF) >>> POS_SHIFT;
    ryw  = (s7_vy + HALF) >>> POS_SHIFT;
    offx = rxw[31:0];
    offy = ryw[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      resp.child_x        <= s7_rev ? s7_px - $signed(offx) : s7_px + $signed(offx);
      resp.child_y        <= s7_rev ? s7_py - $signed(offy) : s7_py + $signed(offy);
      resp.child_heading  <= 16'(s7_ch);
      resp.child_cost     <= s7_cost;
      resp.cost_saturated <= s7_sat;
    end
  end

  // ---------------- checks
  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.cost_saturated |-> resp.child_cost == 32'hFFFF_FFFF)
    else $error("saturated cost not clamped");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !resp_valid |-> req_ready)
    else $error("empty output stage but request not taken");

  a_rst_flush: assert property (@(posedge clk)
    $past(rst) |-> !resp_valid)
    else $error("result valid right after reset");

endmodule
